// ===== rtl/core/nfcrfp_pkg.sv =====
// Shared definitions for the NFC response frame parser.
// Holds phase and status codes, protocol constants and the result word type.
// No dependencies.
package nfcrfp_pkg;

    localparam int unsigned PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_HDR0 = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_HDR2 = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEN  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LCS  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TFI  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CMD  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DATA = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DCS  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_POST = 4'd9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] DIR_TO_HOST       = 8'hD5;
    localparam logic [7:0] START_CODE2       = 8'hFF;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;
    localparam logic [7:0] LEN_OVERHEAD      = 8'd2;
    localparam logic [7:0] MAX_PAYLOAD_LEN   = 8'd253;

    localparam logic REG_EXPECTED_COMMAND = 1'b0;
    localparam logic REG_MAX_PAYLOAD      = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic [7:0] payload_len;
        logic       last;
    } res_t;

endpackage

// ===== rtl/core/nfcrfp_core.sv =====
// Frame checker state and per-byte decision logic of the NFC response parser.
// Depends on nfcrfp_pkg.
module nfcrfp_core
    import nfcrfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       step_en,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output res_t       res
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         flen_reg, flen_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         cmd_reg;
    logic [7:0]         maxp_reg;

    logic [7:0] cmd_exp;
    logic [7:0] plen_cur;
    logic [7:0] plen_lcs;
    logic [7:0] left_dec;
    logic       emit;
    logic [1:0] emit_st;
    logic [7:0] emit_len;

    assign cmd_exp  = cmd_reg + 8'd1;
    assign plen_cur = flen_reg - LEN_OVERHEAD;
    assign plen_lcs = flen_reg - LEN_OVERHEAD;
    assign left_dec = left_reg - 8'd1;

    always_comb begin
        phase_next = phase_reg;
        flen_next  = flen_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        res_valid  = 1'b0;
        res        = '0;
        emit       = 1'b0;
        emit_st    = ST_OK;
        emit_len   = 8'd0;
        unique case (phase_reg)
            PH_HDR1: begin
                sum_next   = sum_reg | rx_byte;
                phase_next = PH_HDR2;
            end
            PH_HDR2: begin
                if ((sum_reg | (rx_byte ^ START_CODE2)) != 8'd0) begin
                    emit    = 1'b1;
                    emit_st = ST_INVALID;
                end else begin
                    sum_next   = 8'd0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                flen_next  = rx_byte;
                phase_next = PH_LCS;
            end
            PH_LCS: begin
                if ((flen_reg + rx_byte) != 8'd0 || flen_reg < LEN_OVERHEAD) begin
                    emit    = 1'b1;
                    emit_st = ST_INVALID;
                end else if (plen_lcs > maxp_reg) begin
                    emit     = 1'b1;
                    emit_st  = ST_NOSPACE;
                    emit_len = plen_lcs;
                end else begin
                    phase_next = PH_TFI;
                end
            end
            PH_TFI: begin
                left_next  = rx_byte ^ DIR_TO_HOST;
                phase_next = PH_CMD;
            end
            PH_CMD: begin
                if (left_reg != 8'd0 || rx_byte != cmd_exp) begin
                    emit     = 1'b1;
                    emit_st  = ST_INVALID;
                    emit_len = plen_cur;
                end else begin
                    sum_next   = DIR_TO_HOST + cmd_exp;
                    left_next  = plen_cur;
                    phase_next = (plen_cur == 8'd0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA: begin
                sum_next  = sum_reg + rx_byte;
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next = PH_DCS;
                end
                res_valid        = 1'b1;
                res.kind         = KIND_DATA;
                res.payload_byte = rx_byte;
                res.status       = ST_OK;
                res.payload_len  = plen_cur;
                res.last         = 1'b0;
            end
            PH_DCS: begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_POST;
            end
            PH_POST: begin
                emit     = 1'b1;
                emit_len = plen_cur;
                emit_st  = (sum_reg != 8'd0 || rx_byte != 8'd0) ? ST_INVALID : ST_OK;
            end
            default: begin
                // first preamble byte; unused codes land here too
                flen_next  = 8'd0;
                left_next  = 8'd0;
                sum_next   = rx_byte;
                phase_next = PH_HDR1;
            end
        endcase
        if (emit) begin
            phase_next      = PH_HDR0;
            flen_next       = 8'd0;
            left_next       = 8'd0;
            sum_next        = 8'd0;
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.payload_byte = 8'd0;
            res.status      = emit_st;
            res.payload_len = emit_len;
            res.last        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR0;
            flen_reg  <= 8'd0;
            left_reg  <= 8'd0;
            sum_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            flen_reg  <= flen_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg  <= 8'd0;
            maxp_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EXPECTED_COMMAND: cmd_reg  <= cfg_wdata;
                REG_MAX_PAYLOAD:      maxp_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_len_set_before_tfi: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TFI) |-> (flen_reg >= LEN_OVERHEAD))
        else $error("frame length below overhead past LCS");

    a_data_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (left_reg != 8'd0))
        else $error("payload phase with no bytes left");

    a_restart_after_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && res_valid && res.kind == KIND_STATUS) |=>
            (phase_reg == PH_HDR0 && sum_reg == 8'd0))
        else $error("parser did not restart after status");
`endif

endmodule

// ===== rtl/core/nfc_response_frame_parser.sv =====
// Result words reach m_* from the output register, or via the skid entry on a stall.
// Throughput: one byte per cycle while s_ready is high; one state update per byte.
// A two-entry output stage (result register plus skid) keeps s_ready high while one
// result waits; s_ready drops only when both entries hold words.
// Reset (aresetn, synchronous, active low): parser waits for a preamble byte,
// expected_command returns to 0, max_payload to 64, output stage empties.
module nfc_response_frame_parser
    import nfcrfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    // received bytes
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // payload bytes and frame status
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_payload_byte,
    output logic [1:0] m_status,
    output logic [7:0] m_payload_len,
    output logic       m_last
);

    logic step_en;
    logic res_valid;
    res_t res;

    // output stage: out_* drives the ports, skid_* catches a word while out is stalled
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;
    logic skid_valid_reg, skid_valid_next;
    res_t skid_reg, skid_next;
    logic drain;
    logic new_word;

    // accept while the skid entry is free
    assign s_ready  = !skid_valid_reg;
    assign step_en  = s_valid && s_ready;
    assign new_word = step_en && res_valid;
    assign drain    = out_valid_reg && m_ready;

    nfcrfp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_en   (step_en),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || drain) begin
            // output slot frees up: refill from skid first, else from the new word
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = new_word;
                out_next       = res;
            end
        end else if (new_word) begin
            // output stalled: park the new word in the skid entry
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers hold without reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_status       = out_reg.status;
    assign m_payload_len  = out_reg.payload_len;
    assign m_last         = out_reg.last;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while output is empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && new_word) |=> skid_valid_reg)
        else $error("word lost while output stalled");

    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == m_kind))
        else $error("last flag does not match word kind");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload_len <= MAX_PAYLOAD_LEN))
        else $error("payload length out of range");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nfc_response_frame_parser: streams received bytes, predicts
// payload and status words in step with each accepted byte and checks every result word.
// Depends on nfcrfp_pkg and the parser RTL only.
module tb;
    import nfcrfp_pkg::*;

    // Ways a generated frame can be spoiled; FL_NONE sends it intact.
    typedef enum int {
        FL_NONE, FL_HEADER, FL_LEN_SUM, FL_SHORT_LEN, FL_DIRECTION,
        FL_COMMAND, FL_DATA_SUM, FL_POSTAMBLE, FL_CUT
    } frame_flaw_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic [7:0] m_payload_byte;
    logic [1:0] m_status;
    logic [7:0] m_payload_len;
    logic       m_last;

    // Bytes waiting to be offered, and the result words the parser owes us.
    logic [7:0] rx_bytes_q[$];
    res_t       frame_words_due[$];
    int         queued_total = 0;
    int         mismatch_count = 0;

    // Idle and stall rates in percent, and the one long receiver hold-off.
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    logic       hold_arm = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;

    // Shadow copy of the registers and of the parser state.
    logic [7:0]         cf_command = 8'd0;
    logic [7:0]         cf_max_payload = MAX_PAYLOAD_RESET;
    logic [PHASE_W-1:0] ps_phase = PH_HDR0;
    logic [7:0]         ps_len = 8'd0;
    logic [7:0]         ps_left = 8'd0;
    logic [7:0]         ps_sum = 8'd0;

    nfc_response_frame_parser i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_status       (m_status),
        .m_payload_len  (m_payload_len),
        .m_last         (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Frame checker prediction
    // ------------------------------------------------------------------

    // Queue the end-of-frame word and drop back to hunting for a preamble.
    function automatic void push_status(logic [1:0] st, logic [7:0] plen);
        res_t w;
        w.kind         = KIND_STATUS;
        w.payload_byte = 8'd0;
        w.status       = st;
        w.payload_len  = plen;
        w.last         = 1'b1;
        frame_words_due.push_back(w);
        ps_phase = PH_HDR0;
        ps_len   = 8'd0;
        ps_left  = 8'd0;
        ps_sum   = 8'd0;
    endfunction

    // Advance the shadow parser by one received byte.
    function automatic void parse_rx_byte(logic [7:0] b);
        res_t       w;
        logic [7:0] cmd;
        logic [7:0] plen;
        logic [7:0] len_sum;
        cmd     = cf_command + 8'd1;
        plen    = ps_len - LEN_OVERHEAD;
        len_sum = ps_len + b;
        case (ps_phase)
            PH_HDR1: begin
                ps_sum   = ps_sum | b;
                ps_phase = PH_HDR2;
            end
            PH_HDR2: begin
                // Both preamble bytes must be zero and the start code must end in FF.
                if ((ps_sum | (b ^ START_CODE2)) != 8'd0) begin
                    push_status(ST_INVALID, 8'd0);
                end else begin
                    ps_sum   = 8'd0;
                    ps_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                ps_len   = b;
                ps_phase = PH_LCS;
            end
            PH_LCS: begin
                // The length checksum wins over the short-length and space checks.
                if (len_sum != 8'd0 || ps_len < LEN_OVERHEAD) begin
                    push_status(ST_INVALID, 8'd0);
                end else if (plen > cf_max_payload) begin
                    push_status(ST_NOSPACE, plen);
                end else begin
                    ps_phase = PH_TFI;
                end
            end
            PH_TFI: begin
                ps_left  = b ^ DIR_TO_HOST;
                ps_phase = PH_CMD;
            end
            PH_CMD: begin
                if (ps_left != 8'd0 || b != cmd) begin
                    push_status(ST_INVALID, plen);
                end else begin
                    ps_sum   = DIR_TO_HOST + cmd;
                    ps_left  = plen;
                    ps_phase = (plen == 8'd0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA: begin
                ps_sum  = ps_sum + b;
                ps_left = ps_left - 8'd1;
                if (ps_left == 8'd0) begin
                    ps_phase = PH_DCS;
                end
                w.kind         = KIND_DATA;
                w.payload_byte = b;
                w.status       = ST_OK;
                w.payload_len  = plen;
                w.last         = 1'b0;
                frame_words_due.push_back(w);
            end
            PH_DCS: begin
                ps_sum   = ps_sum + b;
                ps_phase = PH_POST;
            end
            PH_POST: begin
                if (ps_sum != 8'd0 || b != 8'd0) begin
                    push_status(ST_INVALID, plen);
                end else begin
                    push_status(ST_OK, plen);
                end
            end
            default: begin
                // First preamble byte; unused phase codes land here too.
                ps_len   = 8'd0;
                ps_left  = 8'd0;
                ps_sum   = b;
                ps_phase = PH_HDR1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, predict on each accepted word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_rx
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_byte  = s_rx_byte;
            if (s_valid && s_ready) begin
                parse_rx_byte(s_rx_byte);
                nxt_valid = 1'b0;
            end
            // Hold valid and data while stalled; only refill a free slot.
            if (!nxt_valid && rx_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_byte  = rx_bytes_q.pop_front();
            end
            s_valid   <= nxt_valid;
            s_rx_byte <= nxt_byte;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here so the sender keeps pushing
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_arm && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result word with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch_results
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_words_due.size() == 0) begin
                    $error("result word with no prediction: kind %0d byte %0d status %0d",
                           m_kind, m_payload_byte, m_status);
                    mismatch_count++;
                end else begin
                    want = frame_words_due.pop_front();
                    check_field("kind", int'(want.kind), int'(m_kind));
                    check_field("payload_byte", int'(want.payload_byte),
                                int'(m_payload_byte));
                    check_field("status", int'(want.status), int'(m_status));
                    check_field("payload_len", int'(want.payload_len),
                                int'(m_payload_len));
                    check_field("last", int'(want.last), int'(m_last));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_rx(logic [7:0] b);
        rx_bytes_q.push_back(b);
        queued_total++;
    endfunction

    // Push the n low bytes of v, most significant first.
    function automatic void push_hex(logic [127:0] v, int n);
        for (int i = n - 1; i >= 0; i--) begin
            push_rx(v[i*8 +: 8]);
        end
    endfunction

    function automatic logic busy();
        return rx_bytes_q.size() != 0 || s_valid || frame_words_due.size() != 0;
    endfunction

    // Wait until every byte is taken and every word is back, then let the
    // pipeline settle for bytes that produce no word.
    task automatic wait_drained();
        do @(negedge aclk); while (busy());
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_EXPECTED_COMMAND) begin
            cf_command = val;
        end else begin
            cf_max_payload = val;
        end
    endtask

    // Build a response frame for the current command, spoil it as asked, queue it.
    function automatic void queue_frame(frame_flaw_t flaw, int plen);
        logic [7:0] bytes[$];
        logic [7:0] flip;
        logic [7:0] len;
        logic [7:0] cmd;
        logic [7:0] dsum;
        logic [7:0] pb;
        int         keep;
        flip = 8'h01 << $urandom_range(7);
        len  = 8'(plen + 2);
        cmd  = cf_command + 8'd1;
        dsum = DIR_TO_HOST + cmd;
        bytes.push_back(8'h00);
        bytes.push_back(8'h00);
        bytes.push_back(START_CODE2);
        bytes.push_back(len);
        bytes.push_back(8'(0 - len));
        bytes.push_back(DIR_TO_HOST);
        bytes.push_back(cmd);
        for (int i = 0; i < plen; i++) begin
            pb = 8'($urandom_range(255));
            bytes.push_back(pb);
            dsum = dsum + pb;
        end
        bytes.push_back(8'(0 - dsum));
        bytes.push_back(8'h00);
        keep = bytes.size();
        case (flaw)
            FL_HEADER:    bytes[$urandom_range(2)] ^= flip;
            FL_LEN_SUM: begin
                bytes[4] ^= flip;
                keep = 5;
            end
            FL_SHORT_LEN: begin
                bytes[3] = 8'($urandom_range(1));
                bytes[4] = 8'(0 - bytes[3]);
                keep = 5;
            end
            FL_DIRECTION: bytes[5] ^= flip;
            FL_COMMAND:   bytes[6] ^= flip;
            FL_DATA_SUM:  bytes[bytes.size() - 2] ^= flip;
            FL_POSTAMBLE: bytes[bytes.size() - 1] ^= flip;
            FL_CUT:       keep = int'($urandom_range(1, bytes.size() - 1));
            default: ;
        endcase
        for (int i = 0; i < keep; i++) begin
            push_rx(bytes[i]);
        end
    endfunction

    // Mostly short payloads, now and then one right at the limit.
    function automatic int pick_len(int lim);
        int r;
        r = $urandom_range(99);
        if (r < 88) begin
            return $urandom_range(0, (lim < 10) ? lim : 10);
        end else if (r < 96) begin
            return $urandom_range(0, (lim < 40) ? lim : 40);
        end
        return lim;
    endfunction

    // Queue about n_bytes of traffic: mostly clean frames, some over the
    // limit, some spoiled, a little line noise.
    task automatic run_segment(int n_bytes, int idle_pct, int stall_pct);
        int start;
        int r;
        int lim;
        @(negedge aclk);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        start = queued_total;
        while (queued_total - start < n_bytes) begin
            r   = $urandom_range(99);
            lim = (cf_max_payload > MAX_PAYLOAD_LEN) ? int'(MAX_PAYLOAD_LEN)
                                                     : int'(cf_max_payload);
            if (r < 70) begin
                queue_frame(FL_NONE, pick_len(lim));
            end else if (r < 78 && lim < MAX_PAYLOAD_LEN) begin
                queue_frame(FL_NONE, $urandom_range(lim + 1,
                            (lim + 8 > MAX_PAYLOAD_LEN) ? int'(MAX_PAYLOAD_LEN) : lim + 8));
            end else if (r < 95) begin
                queue_frame(frame_flaw_t'($urandom_range(FL_HEADER, FL_CUT)), pick_len(lim));
            end else begin
                repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int settle;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values of both registers: command 0, limit 64.
        queue_frame(FL_NONE, 0);
        queue_frame(FL_SHORT_LEN, 0);
        queue_frame(FL_LEN_SUM, 0);
        wait_drained();

        // Zero limit: any payload gets the no-space status on the LCS byte.
        write_reg(REG_EXPECTED_COMMAND, 8'h33);
        write_reg(REG_MAX_PAYLOAD, 8'h00);
        push_hex(128'h0000FF03FD, 5);

        // Change the limit after LEN and the command after the direction byte;
        // the frame must be judged with the new values.
        push_hex(128'h0000FF04, 4);
        wait_drained();
        write_reg(REG_MAX_PAYLOAD, 8'h02);
        push_hex(128'hFCD5, 2);
        wait_drained();
        write_reg(REG_EXPECTED_COMMAND, 8'h10);
        push_hex(128'h1100FF1B00, 5);
        wait_drained();

        // Command FF wraps to a response code of 00; empty payload.
        write_reg(REG_EXPECTED_COMMAND, 8'hFF);
        queue_frame(FL_NONE, 0);
        wait_drained();

        // Sender mostly busy, receiver mostly stalled.
        write_reg(REG_EXPECTED_COMMAND, 8'($urandom_range(255)));
        write_reg(REG_MAX_PAYLOAD, 8'd12);
        run_segment(160, 9, 76);
        wait_drained();
        write_reg(REG_EXPECTED_COMMAND, 8'hFF);
        write_reg(REG_MAX_PAYLOAD, 8'h00);
        run_segment(160, 9, 76);
        wait_drained();

        // Sender mostly idle, receiver mostly ready.
        write_reg(REG_EXPECTED_COMMAND, 8'($urandom_range(255)));
        write_reg(REG_MAX_PAYLOAD, 8'hFF);
        run_segment(160, 76, 9);
        wait_drained();
        write_reg(REG_EXPECTED_COMMAND, 8'h00);
        write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(20)));
        run_segment(160, 76, 9);
        wait_drained();

        // Full rate both ways; one long receiver hold-off fills the output stage.
        write_reg(REG_EXPECTED_COMMAND, 8'($urandom_range(255)));
        write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(30)));
        run_segment(160, 0, 0);
        hold_arm = 1'b1;
        wait_drained();
        write_reg(REG_EXPECTED_COMMAND, 8'($urandom_range(255)));
        write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_LEN);
        run_segment(160, 0, 0);

        // Drain with a bound, then flag anything still owed.
        settle = 0;
        while (busy() && settle < 20000) begin
            @(negedge aclk);
            settle++;
        end
        repeat (5) @(negedge aclk);
        if (frame_words_due.size() != 0) begin
            $error("%0d predicted result words never arrived", frame_words_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== nfc_response_frame_parser.f =====
rtl/core/nfcrfp_pkg.sv
rtl/core/nfcrfp_core.sv
rtl/core/nfc_response_frame_parser.sv
verif/tb.sv
